@@ src/hjm_pkg.sv @@
package hjm_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_ACT_X,
        S_ACT_Y,
        S_ACT_R,
        S_SPD,
        S_SPD_E2,
        S_SPD_F2,
        S_DIV,
        S_SPD_FIN,
        S_ANG,
        S_CORDIC,
        S_TURN,
        S_REC_LO,
        S_REC_HI,
        S_REC_FIN,
        S_SQ_INIT,
        S_SQRT,
        S_MUL_LO,
        S_MUL_HI,
        S_TURN_FIN,
        S_OUT
    } t_state;

    // configuration register indexes
    typedef enum logic [3:0] {
        REG_CENTER_X   = 4'd0,
        REG_CENTER_Y   = 4'd1,
        REG_CENTER_Z   = 4'd2,
        REG_ACT_RADIUS = 4'd3,
        REG_HOLE       = 4'd4,
        REG_DONUT      = 4'd5,
        REG_TURN_THR   = 4'd6,
        REG_MAX_TURN   = 4'd7
    } t_reg_idx;

    localparam int DEACT_BUFFER = 640;
    localparam int ATAN_LEN     = 24;
    localparam int ZW           = 27;   // angle, Q16 degrees
    localparam int NUM_W        = 47;   // dividend
    localparam int DEN_W        = 30;   // divisor
    localparam int REM_W        = 31;
    localparam int QUO_W        = 33;
    localparam int CNT_W        = 6;
    localparam int MUL_A_W      = 32;
    localparam int MUL_B_W      = 17;
    localparam int ACC_W        = 65;
    localparam logic [ZW-1:0] DEG180 = ZW'(180 * 65536);
    localparam logic [16:0] SPEED_SAT = 17'd40000;
    // ceil(2^36 / 45), exact floor(u / 45) for u below 2^30
    localparam logic [MUL_A_W-1:0] RECIP_45 = 32'd1527099484;

    // arctangent of 2^-i in Q16 degrees
    function automatic logic [22:0] atan_q16(input logic [4:0] i);
        logic [22:0] v;
        unique case (i)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/hand_joystick_mapper_top.sv @@
// channel | dir | handshake                      | payload
// s       | in  | i_s_tvalid / o_s_tready        | i_s_tdata: palm x,y,z, finger x,y,z
// m       | out | o_m_tvalid / i_m_tready        | o_m_tdata: fwd, right, turn, active
// cfg     | in  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// a frame passes the check and the output stage when the joystick stays idle,
// adds the activation steps when an activation check runs, and while engaged
// also runs both speeds, the cordic and the turn law; the shared restoring divider
// (47 steps per speed) and the 32-step square root set most of it
// reset (i_rst_n low, synchronous) clears the engaged flag, the sequencer,
// the output valid and loads the register defaults
// a stalled output holds the finished beat; the next frame is taken meanwhile
// and waits at the output stage until the pending beat leaves
module hand_joystick_mapper_top import hjm_pkg::*; #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // palm_x, palm_y, palm_z, finger_x, finger_y, finger_z (lowest first)
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // forward_speed, right_speed, turn_rate, active (lowest first)
    output logic [55:0] o_m_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;                       // coordinate difference
    localparam int XW = CW + 19;                      // cordic vector
    localparam int EW = ((CW > 16) ? CW : 16) + 2;    // activation compare
    localparam int SW = ((DW > 17) ? DW : 17) + 2;    // speed compare

    t_state r_state, n_state;

    // configuration
    logic signed [15:0] r_cx, r_cy, r_cz;
    logic [14:0] r_act_r, r_hole, r_donut, r_max_turn;
    logic [7:0]  r_thr;

    // frame and state
    logic signed [CW-1:0] r_px, r_py, r_pz, r_fx, r_fy, r_fz, r_ox, r_oy;
    logic r_eng;

    // datapath
    logic [14:0] r_ax, r_ay;
    logic        r_axis, r_neg;
    logic [16:0] r_e;
    logic [14:0] r_f;
    logic [24:0] r_u;
    logic [ACC_W-1:0] r_acc;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [REM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo, r_p;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0] r_sqn;
    logic [35:0] r_srem;
    logic [31:0] r_root;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [15:0] r_fwd, r_rgt, r_turn;

    // output stage
    logic [55:0] r_m_data;
    logic        r_m_valid;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = r_m_data;
    assign o_m_tvalid  = r_m_valid;

    logic s_acc, out_free;
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;

    // ---- shared multiplier ----
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_ACT_X:  begin mul_a = MUL_A_W'(r_ax);     mul_b = MUL_B_W'(r_ax); end
            S_ACT_Y:  begin mul_a = MUL_A_W'(r_ay);     mul_b = MUL_B_W'(r_ay); end
            S_ACT_R:  begin mul_a = MUL_A_W'(r_act_r);  mul_b = MUL_B_W'(r_act_r); end
            S_SPD_E2: begin mul_a = MUL_A_W'(r_e);      mul_b = r_e; end
            S_SPD_F2: begin mul_a = MUL_A_W'(r_f);      mul_b = MUL_B_W'(r_f); end
            S_REC_LO: begin mul_a = RECIP_45;           mul_b = r_u[16:0]; end
            S_REC_HI: begin mul_a = RECIP_45;           mul_b = MUL_B_W'(r_u[24:17]); end
            S_MUL_LO: begin mul_a = r_root;             mul_b = r_p[16:0]; end
            S_MUL_HI: begin mul_a = r_root;             mul_b = MUL_B_W'(r_p[32:17]); end
            default:  begin mul_a = '0;                 mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // ---- activation checks ----
    logic signed [EW-1:0] fz_e, cz_e, dxa, dya;
    logic [EW-1:0] axa, aya, r_e_w;
    logic above, below, in_box;
    always_comb begin
        fz_e  = EW'(r_fz);
        cz_e  = EW'(r_cz);
        dxa   = EW'(r_fx) - EW'(r_cx);
        dya   = EW'(r_fy) - EW'(r_cy);
        axa   = dxa[EW-1] ? EW'(-dxa) : EW'(dxa);
        aya   = dya[EW-1] ? EW'(-dya) : EW'(dya);
        r_e_w = EW'(r_act_r);
        above = fz_e > cz_e;
        below = fz_e < (cz_e - EW'(DEACT_BUFFER));
        in_box = (axa < r_e_w) && (aya < r_e_w);
    end

    // ---- speed setup ----
    logic signed [DW-1:0] pos;
    logic [DW-1:0] pos_abs;
    logic [SW-1:0] a_s, h_s, d_s, e_s, f_s;
    always_comb begin
        pos = r_axis ? (DW'(r_py) - DW'(r_oy)) : (DW'(r_px) - DW'(r_ox));
        pos_abs = pos[DW-1] ? DW'(-pos) : DW'(pos);
        a_s = SW'(pos_abs);
        h_s = SW'(r_hole);
        d_s = SW'(r_donut);
        e_s = a_s - h_s;
        f_s = d_s - h_s;
    end

    function automatic logic signed [15:0] speed_sat(input logic [16:0] mag,
                                                     input logic neg);
        logic signed [15:0] v;
        if (neg) begin
            v = (mag > 17'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, mag}));
        end else begin
            v = (mag > 17'd32767) ? 16'sh7fff : 16'(mag);
        end
        return v;
    endfunction

    // ---- divider step ----
    logic [REM_W-1:0] rem_sh;
    logic div_ge;
    assign rem_sh = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign div_ge = rem_sh >= REM_W'(r_den);

    // ---- square root step ----
    logic [35:0] srem_sh, trial;
    logic sq_ge;
    assign srem_sh = {r_srem[33:0], r_sqn[63:62]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign sq_ge   = srem_sh >= trial;

    // ---- cordic step ----
    logic signed [XW-1:0] xs, ys;
    logic [4:0] ci;
    assign ci = r_cnt[4:0];
    assign xs = r_x >>> ci;
    assign ys = r_y >>> ci;

    // ---- angle setup ----
    logic signed [DW-1:0] dy, dz;
    assign dy = DW'(r_fy) - DW'(r_py);
    assign dz = DW'(r_fz) - DW'(r_pz);

    // ---- p = floor(u * 2^14 / 90) from k = floor(u / 45), u = 45k + r ----
    // p = 8192k + floor(8192r / 45) = 8192k + 182r + (2r >= 45)
    logic [20:0] rec_k;
    logic [26:0] rec_45k;
    logic [5:0]  rec_r;
    logic [QUO_W-1:0] rec_p;
    always_comb begin
        rec_k   = r_acc[56:36];
        rec_45k = 27'({rec_k, 5'b0}) + 27'({rec_k, 3'b0}) + 27'({rec_k, 2'b0})
                  + 27'(rec_k);
        rec_r   = 6'(27'(r_u) - rec_45k);
        rec_p   = QUO_W'({rec_k, 13'b0}) + QUO_W'(rec_r) * QUO_W'(182)
                  + QUO_W'(rec_r >= 6'd23);
    end

    // ---- turn ----
    logic [ZW-1:0] z_abs, thr_q;
    logic [34:0] q_val;
    logic [37:0] six_q;
    logic [18:0] tmag;
    logic [14:0] tmag_c;
    always_comb begin
        z_abs = r_z[ZW-1] ? ZW'(-r_z) : ZW'(r_z);
        thr_q = ZW'({r_thr, 16'b0});
        q_val = r_acc[64:30];
        six_q = {1'b0, q_val, 2'b00} + {2'b00, q_val, 1'b0};
        tmag  = 19'((six_q + 38'd262144) >> 19);
        tmag_c = (tmag > 19'd32767) ? 15'h7fff : tmag[14:0];
        if (tmag_c > r_max_turn) tmag_c = r_max_turn;
    end

    logic eng_after;
    assign eng_after = r_eng && !(!above && below);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (s_acc) n_state = S_CHECK;
            S_CHECK: begin
                if (above && !r_eng && in_box) n_state = S_ACT_X;
                else if (eng_after) n_state = S_SPD;
                else n_state = S_OUT;
            end
            S_ACT_X:   n_state = S_ACT_Y;
            S_ACT_Y:   n_state = S_ACT_R;
            S_ACT_R:   n_state = (r_acc < ACC_W'(mul_p)) ? S_SPD : S_OUT;
            S_SPD: begin
                if (a_s <= h_s || d_s <= h_s || e_s > ((f_s << 1) + f_s))
                    n_state = r_axis ? S_ANG : S_SPD;
                else
                    n_state = S_SPD_E2;
            end
            S_SPD_E2:  n_state = S_SPD_F2;
            S_SPD_F2:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) n_state = S_SPD_FIN;
            end
            S_SPD_FIN: n_state = r_axis ? S_ANG : S_SPD;
            S_ANG:     n_state = (dy == '0) ? S_TURN : S_CORDIC;
            S_CORDIC:  if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = S_TURN;
            S_TURN:    n_state = (z_abs < thr_q) ? S_OUT : S_REC_LO;
            S_REC_LO:  n_state = S_REC_HI;
            S_REC_HI:  n_state = S_REC_FIN;
            S_REC_FIN: n_state = S_SQ_INIT;
            S_SQ_INIT: n_state = S_SQRT;
            S_SQRT:    if (r_cnt == '0) n_state = S_MUL_LO;
            S_MUL_LO:  n_state = S_MUL_HI;
            S_MUL_HI:  n_state = S_TURN_FIN;
            S_TURN_FIN: n_state = S_OUT;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- configuration and control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= 16'sd3840;
            r_cy <= -16'sd640;
            r_cz <= 16'sd2880;
            r_act_r <= 15'd1280;
            r_hole <= 15'd128;
            r_donut <= 15'd640;
            r_thr <= 8'd10;
            r_max_turn <= 15'd3072;
            r_eng <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CENTER_X:   r_cx <= i_cfg_data;
                    REG_CENTER_Y:   r_cy <= i_cfg_data;
                    REG_CENTER_Z:   r_cz <= i_cfg_data;
                    REG_ACT_RADIUS: r_act_r <= i_cfg_data[14:0];
                    REG_HOLE:       r_hole <= i_cfg_data[14:0];
                    REG_DONUT:      r_donut <= i_cfg_data[14:0];
                    REG_TURN_THR:   r_thr <= i_cfg_data[7:0];
                    REG_MAX_TURN:   r_max_turn <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (r_state == S_CHECK) r_eng <= eng_after;
            if (r_state == S_ACT_R && r_acc < ACC_W'(mul_p)) r_eng <= 1'b1;
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_px <= i_s_tdata[0*CW +: CW];
                    r_py <= i_s_tdata[1*CW +: CW];
                    r_pz <= i_s_tdata[2*CW +: CW];
                    r_fx <= i_s_tdata[3*CW +: CW];
                    r_fy <= i_s_tdata[4*CW +: CW];
                    r_fz <= i_s_tdata[5*CW +: CW];
                end
            end
            S_CHECK: begin
                r_fwd  <= '0;
                r_rgt  <= '0;
                r_turn <= '0;
                r_axis <= 1'b0;
                r_ax   <= axa[14:0];
                r_ay   <= aya[14:0];
            end
            S_ACT_X: r_acc <= ACC_W'(mul_p);
            S_ACT_Y: r_acc <= r_acc + ACC_W'(mul_p);
            S_ACT_R: begin
                if (r_acc < ACC_W'(mul_p)) begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                end
            end
            S_SPD: begin
                r_neg <= pos[DW-1];
                r_e   <= e_s[16:0];
                r_f   <= f_s[14:0];
                if (a_s <= h_s || d_s <= h_s || e_s > ((f_s << 1) + f_s)) begin
                    // dead zone gives zero, far outside the donut saturates
                    if (r_axis) begin
                        r_rgt <= (a_s <= h_s || d_s <= h_s) ? 16'sd0
                                 : speed_sat(SPEED_SAT, pos[DW-1]);
                    end else begin
                        r_fwd <= (a_s <= h_s || d_s <= h_s) ? 16'sd0
                                 : speed_sat(SPEED_SAT, pos[DW-1]);
                        r_axis <= 1'b1;
                    end
                end
            end
            S_SPD_E2: r_acc <= ACC_W'(mul_p);
            S_SPD_F2: begin
                // rounded quotient: (e^2 * 4096 + den/2) / den
                r_den <= DEN_W'(mul_p);
                r_num <= {r_acc[34:0], 12'b0} + NUM_W'(mul_p[DEN_W-1:1]);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CNT_W'(NUM_W - 1);
            end
            S_DIV: begin
                r_rem <= div_ge ? (rem_sh - REM_W'(r_den)) : rem_sh;
                r_quo <= {r_quo[QUO_W-2:0], div_ge};
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            S_SPD_FIN: begin
                if (r_axis) begin
                    r_rgt <= speed_sat(r_quo[16:0], r_neg);
                end else begin
                    r_fwd <= speed_sat(r_quo[16:0], r_neg);
                    r_axis <= 1'b1;
                end
            end
            S_ANG: begin
                r_cnt <= '0;
                if (dy == '0) begin
                    r_z <= dz[DW-1] ? $signed(DEG180) : '0;
                end else if (dz[DW-1]) begin
                    r_x <= -$signed({{2{dz[DW-1]}}, dz, 16'b0});
                    r_y <= -$signed({{2{dy[DW-1]}}, dy, 16'b0});
                    r_z <= dy[DW-1] ? -$signed(DEG180) : $signed(DEG180);
                end else begin
                    r_x <= {{2{dz[DW-1]}}, dz, 16'b0};
                    r_y <= {{2{dy[DW-1]}}, dy, 16'b0};
                    r_z <= '0;
                end
            end
            S_CORDIC: begin
                if (!r_y[XW-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + $signed(ZW'(atan_q16(ci)));
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - $signed(ZW'(atan_q16(ci)));
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_TURN: begin
                // u = |angle| - threshold, divided by 90 through a reciprocal
                r_neg <= r_z[ZW-1];
                r_u   <= 25'(z_abs - thr_q);
            end
            S_REC_LO: r_acc <= ACC_W'(mul_p);
            S_REC_HI: r_acc <= r_acc + (ACC_W'(mul_p) << 17);
            S_REC_FIN: r_quo <= rec_p;
            S_SQ_INIT: begin
                r_p    <= r_quo;
                r_sqn  <= {1'b0, r_quo, 30'b0};
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(31);
            end
            S_SQRT: begin
                r_srem <= sq_ge ? (srem_sh - trial) : srem_sh;
                r_root <= {r_root[30:0], sq_ge};
                r_sqn  <= {r_sqn[61:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
            end
            S_MUL_LO: r_acc <= ACC_W'(mul_p);
            S_MUL_HI: r_acc <= r_acc + (ACC_W'(mul_p) << 17);
            S_TURN_FIN: begin
                r_turn <= r_neg ? 16'(-$signed({1'b0, tmag_c}))
                                : 16'(tmag_c);
            end
            S_OUT: begin
                if (out_free) begin
                    r_m_data <= {7'b0, r_eng, r_turn, r_rgt, r_fwd};
                end
            end
            default: ;
        endcase
    end

    // ---- checks ----
    logic signed [15:0] out_turn;
    logic [16:0] out_turn_mag;
    assign out_turn     = o_m_tdata[47:32];
    assign out_turn_mag = out_turn[15] ? 17'(-$signed({out_turn[15], out_turn}))
                                       : 17'(out_turn);

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[48] |-> o_m_tdata[47:0] == 48'd0)
        else $error("disengaged beat carries nonzero rates");

    a_turn_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> out_turn_mag <= 17'(r_max_turn))
        else $error("turn rate beyond limit");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("ready right after a frame was taken");

endmodule

@@ tb/sv/hand_joystick_mapper_checker.sv @@
module hand_joystick_mapper_checker import hjm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [95:0] i_s_tdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_m_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_failures,
    output int          o_pending,
    output int          o_results,
    output int          o_engaged_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;

    typedef struct {
        logic signed [15:0] fwd;
        logic signed [15:0] rgt;
        logic signed [15:0] turn;
        logic               active;
    } t_joy_out;

    const longint atan_tbl[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    longint   cx, cy, cz, act_r, hole_r, donut_r, thr, max_turn;
    bit       engaged;
    longint   org_x, org_y;
    t_joy_out joy_q[$];

    function automatic longint speed_law(longint pos);
        longint a, mag;
        a = (pos < 0) ? -pos : pos;
        if (a <= hole_r || donut_r <= hole_r)
            return 0;
        if (a - hole_r > 3 * (donut_r - hole_r)) begin
            mag = 40000;
        end else begin
            mag = ((a - hole_r) * (a - hole_r) * 4096
                   + ((donut_r - hole_r) * (donut_r - hole_r)) / 2)
                  / ((donut_r - hole_r) * (donut_r - hole_r));
        end
        if (pos < 0)
            return (mag > 32768) ? -32768 : -mag;
        return (mag > 32767) ? 32767 : mag;
    endfunction

    // tilt angle in Q16 degrees, vectoring-mode cordic toward y = 0
    function automatic longint tilt_angle(longint dy, longint dz);
        longint x, y, z, xn;
        z = 0;
        if (dy == 0)
            return (dz < 0) ? 180 * 65536 : 0;
        x = dz * 65536;
        y = dy * 65536;
        if (dz < 0) begin
            x = -x;
            y = -y;
            z = (dy > 0) ? 180 * 65536 : -180 * 65536;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y >= 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_tbl[i];
            end else begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_tbl[i];
            end
            x = xn;
        end
        return z;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] n);
        bit [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint turn_law(longint ang);
        longint    a, t;
        bit [63:0] p, s, q, mag;
        a = (ang < 0) ? -ang : ang;
        t = thr * 65536;
        if (a < t)
            return 0;
        p   = (64'(a - t) << 14) / 90;
        s   = int_sqrt(p << 30);
        q   = (p * s) >> 30;
        mag = (6 * q + (64'd1 << 18)) >> 19;
        if (mag > 32767)
            mag = 32767;
        if (mag > 64'(max_turn))
            mag = 64'(max_turn);
        return (ang < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic t_joy_out joystick_frame(logic [95:0] d);
        longint   px, py, pz, fx, fy, fz, dx, dy;
        t_joy_out r;
        px = longint'($signed(d[15:0]));
        py = longint'($signed(d[31:16]));
        pz = longint'($signed(d[47:32]));
        fx = longint'($signed(d[63:48]));
        fy = longint'($signed(d[79:64]));
        fz = longint'($signed(d[95:80]));
        if (fz > cz) begin
            if (!engaged) begin
                dx = fx - cx;
                dy = fy - cy;
                if ((dx < 0 ? -dx : dx) < act_r && (dy < 0 ? -dy : dy) < act_r
                    && dx * dx + dy * dy < act_r * act_r) begin
                    engaged = 1;
                    org_x   = px;
                    org_y   = py;
                end
            end
        end else if (engaged && fz < cz - DEACT_BUFFER) begin
            engaged = 0;
        end
        r.fwd = '0;
        r.rgt = '0;
        r.turn = '0;
        r.active = engaged;
        if (engaged) begin
            r.fwd  = 16'(speed_law(px - org_x));
            r.rgt  = 16'(speed_law(py - org_y));
            r.turn = 16'(turn_law(tilt_angle(fy - py, fz - pz)));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_joy_out e, got;
        if (!i_rst_n) begin
            cx = 3840; cy = -640; cz = 2880;
            act_r = 1280; hole_r = 128; donut_r = 640;
            thr = 10; max_turn = 3072;
            engaged = 0; org_x = 0; org_y = 0;
        end else begin
            // register writes land before any frame of the same edge
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER_X:   cx = longint'($signed(i_cfg_data));
                    REG_CENTER_Y:   cy = longint'($signed(i_cfg_data));
                    REG_CENTER_Z:   cz = longint'($signed(i_cfg_data));
                    REG_ACT_RADIUS: act_r = longint'(i_cfg_data[14:0]);
                    REG_HOLE:       hole_r = longint'(i_cfg_data[14:0]);
                    REG_DONUT:      donut_r = longint'(i_cfg_data[14:0]);
                    REG_TURN_THR:   thr = longint'(i_cfg_data[7:0]);
                    REG_MAX_TURN:   max_turn = longint'(i_cfg_data[14:0]);
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                joy_q.push_back(joystick_frame(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.fwd    = i_m_tdata[15:0];
                got.rgt    = i_m_tdata[31:16];
                got.turn   = i_m_tdata[47:32];
                got.active = i_m_tdata[48];
                o_results++;
                if (got.active)
                    o_engaged_results++;
                if (joy_q.size() == 0) begin
                    $error("unexpected output beat %h", i_m_tdata);
                    o_failures++;
                end else begin
                    e = joy_q.pop_front();
                    if (got.fwd !== e.fwd) begin
                        $error("forward_speed exp %0d got %0d", e.fwd, got.fwd);
                        o_failures++;
                    end
                    if (got.rgt !== e.rgt) begin
                        $error("right_speed exp %0d got %0d", e.rgt, got.rgt);
                        o_failures++;
                    end
                    if (got.turn !== e.turn) begin
                        $error("turn_rate exp %0d got %0d", e.turn, got.turn);
                        o_failures++;
                    end
                    if (got.active !== e.active) begin
                        $error("active exp %0d got %0d", e.active, got.active);
                        o_failures++;
                    end
                    if (i_m_tdata[55:49] !== '0) begin
                        $error("pad bits exp 0 got %h", i_m_tdata[55:49]);
                        o_failures++;
                    end
                end
            end
        end
        o_pending = joy_q.size();
    end

    initial begin
        o_failures = 0;
        o_pending = 0;
        o_results = 0;
        o_engaged_results = 0;
    end

endmodule

@@ tb/sv/hand_joystick_mapper_top_tb.sv @@
module hand_joystick_mapper_top_tb;
    import hjm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int           CYCLE_LIMIT = 3000000;
    localparam int           DRAIN_WAIT  = 300;   // more than one engaged frame
    localparam int           LONG_HOLD   = 4000;
    localparam int           RAND_FRAMES = 1430;
    localparam logic [3:0]   REG_UNUSED  = 4'd11;

    // frame kinds for the stimulus generator
    typedef enum int { K_ENGAGE, K_HOLD, K_BAND, K_RELEASE, K_NOISE } t_kind;

    logic        i_clk;
    logic        i_rst_n;
    // palm_x, palm_y, palm_z, finger_x, finger_y, finger_z (lowest first)
    logic [95:0] i_s_tdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    // forward_speed, right_speed, turn_rate, active, zero pad (lowest first)
    logic [55:0] o_m_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int failures, pending, results, engaged_results;
    int cycles;
    int frames_sent;
    bit long_hold_req;

    // mirror of the register settings, used only to aim the stimulus
    int cur_cx, cur_cy, cur_cz, cur_ar, cur_hr, cur_dr;
    // palm position at the last engaging frame
    int base_px, base_py;

    hand_joystick_mapper_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    hand_joystick_mapper_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tdata         (i_s_tdata),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_failures        (failures),
        .o_pending         (pending),
        .o_results         (results),
        .o_engaged_results (engaged_results)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("hand_joystick_mapper_top test failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(4, 1);
        return $urandom_range(80, 20);
    endfunction

    function automatic int srnd(int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_m_tready = 0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 0;
            end else if ($urandom_range(9) < 3) begin
                i_m_tready = 0;
                repeat (gap_len()) @(negedge i_clk);
            end
            i_m_tready = 1;
        end
    end

    // called at a falling edge; ready is stable there until the next rise
    task automatic send_beat(logic [95:0] d);
        i_s_tdata  = d;
        i_s_tvalid = 1;
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        frames_sent++;
        @(negedge i_clk);
        i_s_tvalid = 0;
        repeat (gap_len()) @(negedge i_clk);
    endtask

    task automatic send_frame(int px, int py, int pz, int fx, int fy, int fz);
        send_beat({16'(fz), 16'(fy), 16'(fx), 16'(pz), 16'(py), 16'(px)});
    endtask

    task automatic cfg_write(logic [3:0] idx, logic [15:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // writes all registers once the block has drained
    task automatic apply_settings(int cx, int cy, int cz, int ar, int hr, int dr,
                                  int thr, int mt);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        cfg_write(REG_CENTER_X, 16'(cx));
        cfg_write(REG_CENTER_Y, 16'(cy));
        cfg_write(REG_CENTER_Z, 16'(cz));
        cfg_write(REG_ACT_RADIUS, 16'(ar));
        cfg_write(REG_HOLE, 16'(hr));
        cfg_write(REG_DONUT, 16'(dr));
        cfg_write(REG_TURN_THR, 16'(thr));
        cfg_write(REG_MAX_TURN, 16'(mt));
        // an index past the list must be ignored
        cfg_write(REG_UNUSED, 16'($urandom));
        cur_cx = cx; cur_cy = cy; cur_cz = cz;
        cur_ar = ar; cur_hr = hr; cur_dr = dr;
    endtask

    task automatic random_frame(t_kind k);
        int px, py, pz, fx, fy, fz, dy, dz, span, rad;
        span = cur_dr * 4 + 200;
        rad  = cur_ar * 7 / 10;
        px = base_px + srnd(span);
        py = base_py + srnd(span);
        fx = srnd(32768);
        fy = 0;
        fz = 0;
        case (k)
            K_ENGAGE: begin
                px = srnd(20000);
                py = srnd(20000);
                fx = cur_cx + srnd(rad);
                fy = cur_cy + srnd(rad);
                fz = cur_cz + $urandom_range(2000, 1);
                base_px = px;
                base_py = py;
            end
            K_HOLD:    fz = cur_cz + srnd(600) + 700;
            K_BAND:    fz = cur_cz - $urandom_range(640);
            K_RELEASE: fz = cur_cz - 641 - $urandom_range(3000);
            default: ;
        endcase
        if (k == K_NOISE) begin
            send_beat({$urandom, $urandom, $urandom});
        end else begin
            dy = ($urandom_range(9) == 0) ? 0 : srnd(3000);
            dz = srnd(3000);
            if (k != K_ENGAGE)
                fy = py + dy;
            pz = fz - dz;
            send_frame(px, py, pz, fx, fy, fz);
        end
    endtask

    // well-formed engage / hold / release sessions, with some noise
    task automatic random_phase(int n);
        int target;
        target = frames_sent + n;
        while (frames_sent < target) begin
            if ($urandom_range(9) < 8) begin
                random_frame(($urandom_range(9) < 8) ? K_ENGAGE : K_NOISE);
                repeat ($urandom_range(12, 1))
                    random_frame(($urandom_range(9) == 0) ? K_BAND : K_HOLD);
                random_frame(K_RELEASE);
            end else begin
                random_frame(K_NOISE);
            end
        end
    endtask

    initial begin
        cycles = 0;
        frames_sent = 0;
        long_hold_req = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cur_cx = 3840; cur_cy = -640; cur_cz = 2880;
        cur_ar = 1280; cur_hr = 128; cur_dr = 640;
        base_px = 0; base_py = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed, reset settings
        send_frame(0, 0, 0, 0, 0, 0);                      // idle, finger low
        send_frame(0, 0, 0, 3840 + 1280, -640, 2881);      // on radius edge, no engage
        send_frame(0, 0, 0, 3840 + 900, -640 + 900, 2881); // in square and disk: engages
        send_frame(0, 0, 2000, 3840, -640, 2881);          // at center, already engaged
        send_frame(100, 0, 2000, 0, 0, 3000);              // re-engage attempt ignored
        send_frame(128, -128, 2000, 0, 0, 3000);           // offsets at hole edge
        send_frame(129, -129, 2000, 0, 0, 3000);           // just past hole
        send_frame(1664, -1664, 2000, 0, 0, 3000);         // saturating speed
        send_frame(32767, -32768, 2000, 0, 0, 3000);       // field extremes
        send_frame(0, 0, 2000, 0, 0, 3000);                // tilt dy zero, dz positive
        send_frame(0, 0, 3500, 0, 0, 3000);                // tilt dy zero, dz negative
        send_frame(0, 0, 3500, 0, 500, 3000);              // dz negative, dy positive
        send_frame(0, 0, 3500, 0, -500, 3000);             // dz negative, dy negative
        send_frame(0, 0, 2000, 0, 176, 3000);              // near turn threshold
        send_frame(0, 0, 2000, 0, 500, 3000);              // moderate tilt
        send_frame(0, 0, 2500, 0, 0, 2880);                // at the plane: kept
        send_frame(0, 0, 2000, 0, 0, 2240);                // buffer edge: kept
        send_frame(0, 0, 2000, 0, 0, 2239);                // below buffer: released
        send_frame(-32768, -32768, -32768, -32768, -32768, -32768);
        send_frame(32767, 32767, 32767, 32767, 32767, 32767);
        send_frame(-1, -1, -1, 3840, -640, 32767);         // engage, all ones palm
        send_frame(-1, -1, -1, 0, 0, -32768);              // release

        // random phases across settings, extremes included
        random_phase(RAND_FRAMES / 8);
        apply_settings(0, 0, 0, 32767, 0, 0, 0, 32767);    // hole >= donut, speeds stay zero
        random_phase(RAND_FRAMES / 8);
        apply_settings(-32768, 32767, -32768, 0, 0, 1, 255, 0); // never engages
        random_phase(RAND_FRAMES / 16);
        apply_settings(32767, -32768, 32767, 32767, 32767, 32767, 180, 1);
        random_phase(RAND_FRAMES / 16);
        apply_settings(-1000, 1000, -500, 5000, 64, 2000, 0, 32767);
        long_hold_req = 1;                                 // output backs up here
        random_phase(RAND_FRAMES / 4);
        apply_settings(500, -700, 1000, 3000, 300, 280, 45, 20000);
        random_phase(RAND_FRAMES / 8);
        apply_settings(3840, -640, 2880, 1280, 128, 640, 10, 3072);
        random_phase(RAND_FRAMES / 4);

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("frames sent %0d, results checked %0d, engaged results %0d",
                 frames_sent, results, engaged_results);
        $display("covered engage, hold, release bands, noise and register extremes");
        if (failures == 0 && pending == 0) begin
            $display("hand_joystick_mapper_top test passed");
        end else begin
            $display("hand_joystick_mapper_top test failed");
        end
        $finish;
    end

endmodule
